// ----- hdl/sshash_pkg.sv -----
// shared types and constants for the subset-sum hash block
`default_nettype none

package sshash_pkg;

    // item kinds, same codes as the func field
    localparam logic [1:0] KIND_MATRIX = 2'd0;
    localparam logic [1:0] KIND_SALT   = 2'd1;
    localparam logic [1:0] KIND_BYTE   = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int         LEN_BYTES = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  row;
        logic [9:0]  col;
        logic [2:0]  sidx;
        logic [63:0] value;
        logic [7:0]  dbyte;
    } item_t;

endpackage

`default_nettype wire

// ----- hdl/sshash_front.sv -----
// input side: takes stream words, drops out-of-range writes, queues the rest
`default_nettype none

module sshash_front
    import sshash_pkg::*;
#(
    parameter int ROWS        = 8,
    parameter int COLUMNS     = 1024,
    parameter int BLOCK_BYTES = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [S_USER_W-1:0] s_tuser,
    output logic                     q_valid,
    output item_t                    q_item,
    input  wire logic                q_pop
);

    localparam int SW = (BLOCK_BYTES + 7) / 8;

    item_t                in_item;
    logic                 keep;
    logic                 push;
    item_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wptr_reg, wptr_next;
    logic [FIFO_AW-1:0]   rptr_reg, rptr_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;

    always_comb
    begin
        in_item.kind  = s_tuser[1:0];
        in_item.row   = s_tdata[2:0];
        in_item.col   = s_tdata[12:3];
        in_item.sidx  = s_tdata[15:13];
        in_item.value = s_tdata[79:16];
        in_item.dbyte = s_tdata[87:80];
    end

    always_comb
    begin
        case (in_item.kind)
            KIND_MATRIX: keep = (32'(in_item.row) < ROWS) && (32'(in_item.col) < COLUMNS);
            KIND_SALT:   keep = 32'(in_item.sidx) < SW;
            default:     keep = 1'b1;
        endcase
    end

    assign s_tready = cnt_reg != (FIFO_AW+1)'(FIFO_DEPTH);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = cnt_reg != '0;
    assign q_item   = fifo_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + FIFO_AW'(1) : wptr_reg;
        rptr_next = q_pop ? rptr_reg + FIFO_AW'(1) : rptr_reg;
        cnt_next  = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sshash_core.sv -----
// back end: stores, byte buffer, padding sequencer, column-serial compression
`default_nettype none

module sshash_core
    import sshash_pkg::*;
#(
    parameter int ROWS        = 8,
    parameter int COLUMNS     = 1024,
    parameter int BLOCK_BYTES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        salt_en,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      out_word,
    output logic [2:0]       out_index,
    output logic             out_last
);

    localparam int BBITS = BLOCK_BYTES * 8;
    localparam int VB    = ROWS * 64 + BBITS;
    localparam int STEPS = (COLUMNS < VB) ? COLUMNS : VB;
    localparam int AW    = $clog2(COLUMNS);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FW    = $clog2(BLOCK_BYTES + 1);
    localparam int SW    = (BLOCK_BYTES + 7) / 8;
    localparam int SIW   = (SW > 1) ? $clog2(SW) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_COMP  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_PAD  = 2'd1;
    localparam logic [1:0] RET_OUT  = 2'd2;

    logic [2:0]      state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [127:0]    cnt_reg, cnt_next;
    logic            started_reg, started_next;
    logic [1:0]      ret_reg, ret_next;
    logic            pad_first_reg, pad_first_next;
    logic            len_ok_reg, len_ok_next;
    logic [RW-1:0]   orow_reg, orow_next;
    logic [AW-1:0]   col_reg, col_next;
    logic            ovalid_reg, ovalid_next;
    logic [63:0]     oword_reg, oword_next;
    logic [2:0]      oidx_reg, oidx_next;
    logic            olast_reg, olast_next;

    logic [63:0]     chain_reg [ROWS];
    logic [63:0]     acc_reg [ROWS];
    logic [63:0]     mem_q [ROWS];
    logic [63:0]     salt_reg [SW];
    logic [VB-1:0]   vec_reg;
    logic            bit_q_reg;
    logic            acc_en_reg;
    logic [BBITS-1:0] buf_reg;

    logic [ROWS*64-1:0] chain_flat;
    logic [SW*64-1:0]   salt_flat;
    logic [BBITS-1:0]   blk_bits;

    logic            cmp_start, cmp_zero, buf_shift, mat_we, salt_we, chain_clr;
    logic [7:0]      buf_byte;
    logic [7:0]      pad_byte;
    logic [3:0]      cidx;
    logic [7:0]      cbyte;
    logic            in_len;

    for (genvar r = 0; r < ROWS; r++)
    begin : g_flat
        assign chain_flat[r*64 +: 64] = chain_reg[r];
    end
    for (genvar s = 0; s < SW; s++)
    begin : g_salt
        assign salt_flat[s*64 +: 64] = salt_reg[s];
    end

    // the byte that completes the block is shifted in on the same edge
    assign blk_bits = (cmp_zero ? '0 : {buf_byte, buf_reg[BBITS-1:8]})
                    ^ (salt_en ? salt_flat[BBITS-1:0] : '0);

    // length bytes sit in the last sixteen positions of the final block
    assign cidx     = 4'(fill_reg - FW'(BLOCK_BYTES - LEN_BYTES));
    assign cbyte    = 8'(cnt_reg >> {cidx, 3'b000});
    assign in_len   = len_ok_reg && (fill_reg >= FW'(BLOCK_BYTES - LEN_BYTES));
    assign pad_byte = pad_first_reg ? PAD_BYTE : (in_len ? cbyte : 8'h00);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        started_next   = started_reg;
        ret_next       = ret_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        orow_next      = orow_reg;
        col_next       = col_reg;
        ovalid_next    = ovalid_reg && !out_ready;
        oword_next     = oword_reg;
        oidx_next      = oidx_reg;
        olast_next     = olast_reg;
        q_pop          = 1'b0;
        cmp_start      = 1'b0;
        cmp_zero       = 1'b0;
        buf_shift      = 1'b0;
        buf_byte       = q_item.dbyte;
        mat_we         = 1'b0;
        salt_we        = 1'b0;
        chain_clr      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        KIND_MATRIX:
                        begin
                            q_pop  = 1'b1;
                            mat_we = 1'b1;
                        end
                        KIND_SALT:
                        begin
                            q_pop   = 1'b1;
                            salt_we = 1'b1;
                        end
                        default:
                        begin
                            if (!started_reg && salt_en)
                            begin
                                // salted message opens with a zero block, item stays queued
                                cmp_start    = 1'b1;
                                cmp_zero     = 1'b1;
                                cnt_next     = cnt_reg + 128'(BBITS);
                                started_next = 1'b1;
                                ret_next     = RET_IDLE;
                                col_next     = '0;
                                state_next   = ST_COMP;
                            end
                            else if (q_item.kind == KIND_BYTE)
                            begin
                                q_pop        = 1'b1;
                                started_next = 1'b1;
                                buf_shift    = 1'b1;
                                cnt_next     = cnt_reg + 128'd8;
                                if (fill_reg == FW'(BLOCK_BYTES - 1))
                                begin
                                    fill_next  = '0;
                                    cmp_start  = 1'b1;
                                    ret_next   = RET_IDLE;
                                    col_next   = '0;
                                    state_next = ST_COMP;
                                end
                                else
                                begin
                                    fill_next = fill_reg + FW'(1);
                                end
                            end
                            else
                            begin
                                q_pop          = 1'b1;
                                started_next   = 1'b1;
                                pad_first_next = 1'b1;
                                len_ok_next    = fill_reg < FW'(BLOCK_BYTES - LEN_BYTES);
                                state_next     = ST_PAD;
                            end
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                buf_shift      = 1'b1;
                buf_byte       = pad_byte;
                pad_first_next = 1'b0;
                if (fill_reg == FW'(BLOCK_BYTES - 1))
                begin
                    fill_next   = '0;
                    cmp_start   = 1'b1;
                    col_next    = '0;
                    ret_next    = len_ok_reg ? RET_OUT : RET_PAD;
                    len_ok_next = 1'b1;
                    state_next  = ST_COMP;
                end
                else
                begin
                    fill_next = fill_reg + FW'(1);
                end
            end
            ST_COMP:
            begin
                col_next = col_reg + AW'(1);
                if (col_reg == AW'(STEPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                case (ret_reg)
                    RET_PAD: state_next = ST_PAD;
                    RET_OUT:
                    begin
                        orow_next  = '0;
                        state_next = ST_OUT;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = chain_reg[orow_reg];
                    oidx_next   = 3'(orow_reg);
                    olast_next  = orow_reg == RW'(ROWS - 1);
                    if (orow_reg == RW'(ROWS - 1))
                    begin
                        chain_clr    = 1'b1;
                        cnt_next     = '0;
                        fill_next    = '0;
                        started_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        orow_next = orow_reg + RW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            ret_reg       <= RET_IDLE;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            orow_reg      <= '0;
            col_reg       <= '0;
            ovalid_reg    <= 1'b0;
            acc_en_reg    <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                chain_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
            ret_reg       <= ret_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            orow_reg      <= orow_next;
            col_reg       <= col_next;
            ovalid_reg    <= ovalid_next;
            acc_en_reg    <= state_reg == ST_COMP;
            for (int r = 0; r < ROWS; r++)
            begin
                if (state_reg == ST_DONE)
                begin
                    chain_reg[r] <= acc_reg[r];
                end
                else if (chain_clr)
                begin
                    chain_reg[r] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oword_reg <= oword_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
        if (buf_shift)
        begin
            buf_reg <= {buf_byte, buf_reg[BBITS-1:8]};
        end
        if (salt_we)
        begin
            salt_reg[SIW'(q_item.sidx)] <= q_item.value;
        end
        // vector walks out lsb first, one column per cycle
        if (cmp_start)
        begin
            vec_reg <= {blk_bits, chain_flat};
        end
        else if (state_reg == ST_COMP)
        begin
            vec_reg <= vec_reg >> 1;
        end
        bit_q_reg <= vec_reg[0];
        for (int r = 0; r < ROWS; r++)
        begin
            if (cmp_start)
            begin
                acc_reg[r] <= '0;
            end
            else if (acc_en_reg && bit_q_reg)
            begin
                acc_reg[r] <= acc_reg[r] + mem_q[r];
            end
        end
    end

    // one matrix bank per row, all read at the same column
    for (genvar r = 0; r < ROWS; r++)
    begin : g_bank
        logic [63:0] bank [COLUMNS];

        always_ff @(posedge clk)
        begin
            if (mat_we && (32'(q_item.row) == r))
            begin
                bank[AW'(q_item.col)] <= q_item.value;
            end
            mem_q[r] <= bank[col_reg];
        end
    end

    assign out_valid = ovalid_reg;
    assign out_word  = oword_reg;
    assign out_index = oidx_reg;
    assign out_last  = olast_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FW'(BLOCK_BYTES))
        else $error("fill level out of range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE) && q_valid)
        else $error("queue popped outside idle");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && olast_reg |-> oidx_reg == 3'(ROWS - 1))
        else $error("last word with wrong index");

    a_comp_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) && (col_reg == AW'(STEPS - 1)) |=> state_reg == ST_DRAIN)
        else $error("compression did not end on last column");

    a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && (state_next == ST_IDLE) |=> !started_reg && cnt_reg == '0)
        else $error("message state not cleared after digest");

endmodule

`default_nettype wire

// ----- hdl/subset_sum_hash_512.sv -----
// Subset-sum hash (sumhash512 style) with Merkle-Damgard chaining. Stream words carry matrix
// writes, salt writes, message bytes or a finish; a finish yields ROWS digest words. Words go
// through a four-entry queue, so input is taken while the back end works. Each compression
// walks min(COLUMNS, ROWS*64 + BLOCK_BYTES*8) columns, stepped by the single column counter
// that drives all ROWS matrix banks in parallel, one bank read port each. A finish adds the
// pad bytes, one or two compressions and ROWS output words. With salting on, a message first
// spends one compression on a zero block.
// salt_enable is to be written only while the block is idle.
`default_nettype none

module subset_sum_hash_512
    import sshash_pkg::*;
#(
    parameter int ROWS        = 8,
    parameter int COLUMNS     = 1024,
    parameter int BLOCK_BYTES = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data,     // salt_enable
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,      // matrix_row, matrix_col, salt_index, value, data_byte
    input  wire logic [S_USER_W-1:0] s_tuser,      // func
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,      // digest_word, word_index, zero fill
    output logic                     m_tlast
);

    logic        salt_en_reg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;
    logic [63:0] out_word;
    logic [2:0]  out_index;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            salt_en_reg <= cfg_data;
        end
    end

    sshash_front #(
        .ROWS        (ROWS),
        .COLUMNS     (COLUMNS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sshash_core #(
        .ROWS        (ROWS),
        .COLUMNS     (COLUMNS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .salt_en   (salt_en_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'b00000, out_index, out_word};

endmodule

`default_nettype wire

// ----- verif/tb_subset_sum_hash_512.sv -----
// testbench for subset_sum_hash_512: stream stimulus checked against a behavioral hash predictor
`timescale 1ns / 1ps

module tb_subset_sum_hash_512;
    import sshash_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 3500;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  row;
        logic [9:0]  col;
        logic [2:0]  sidx;
        logic [63:0] value;
        logic [7:0]  dbyte;
    } stim_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // predictor state
    logic [63:0]  mat [8][1024];
    logic [63:0]  salt_w [8];
    logic [63:0]  chain [8];
    logic [511:0] blk_buf;
    logic [127:0] bit_cnt;
    int           fill;
    bit           started;
    bit           salt_on;

    digest_t digest_q [$];
    int      errors = 0;
    int      quiet_cycles = 0;
    bit      calm = 1'b0;

    subset_sum_hash_512 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // one compression: chain words then block bytes form the bit vector
    task automatic compress_block(input logic [511:0] blk);
        logic [1023:0] vec;
        logic [511:0]  salt_bits;
        logic [63:0]   acc;
        for (int i = 0; i < 8; i++)
        begin
            vec[i*64 +: 64] = chain[i];
            salt_bits[i*64 +: 64] = salt_w[i];
        end
        vec[1023:512] = salt_on ? (blk ^ salt_bits) : blk;
        for (int r = 0; r < 8; r++)
        begin
            acc = '0;
            for (int j = 0; j < 1024; j++)
                if (vec[j])
                    acc += mat[r][j];
            chain[r] = acc;
        end
    endtask

    task automatic absorb_item(input stim_t it);
        digest_t d;
        case (it.kind)
            KIND_MATRIX: mat[it.row][it.col] = it.value;
            KIND_SALT:   salt_w[it.sidx] = it.value;
            default:
            begin
                if (!started && salt_on)
                begin
                    compress_block('0);
                    bit_cnt += 128'd512;
                end
                started = 1'b1;
                if (it.kind == KIND_BYTE)
                begin
                    blk_buf[fill*8 +: 8] = it.dbyte;
                    bit_cnt += 128'd8;
                    fill++;
                    if (fill == 64)
                    begin
                        compress_block(blk_buf);
                        fill = 0;
                    end
                end
                else
                begin
                    blk_buf[fill*8 +: 8] = PAD_BYTE;
                    for (int i = fill + 1; i < 64; i++)
                        blk_buf[i*8 +: 8] = 8'h00;
                    // no room for the length: spill into an extra block
                    if (fill >= 64 - LEN_BYTES)
                    begin
                        compress_block(blk_buf);
                        blk_buf = '0;
                    end
                    blk_buf[511:384] = bit_cnt;
                    compress_block(blk_buf);
                    for (int i = 0; i < 8; i++)
                    begin
                        d.word = chain[i];
                        d.idx  = 3'(i);
                        d.last = (i == 7);
                        digest_q.push_back(d);
                        chain[i] = '0;
                    end
                    bit_cnt = '0;
                    fill = 0;
                    started = 1'b0;
                end
            end
        endcase
    endtask

    task automatic send_item(input stim_t it);
        if (!calm)
            while ($urandom_range(0, 99) < 33)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.dbyte, it.value, it.sidx, it.col, it.row};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        absorb_item(it);
    endtask

    function automatic stim_t rand_item(input logic [1:0] kind);
        stim_t it;
        it.kind  = kind;
        it.row   = 3'($urandom);
        it.col   = 10'($urandom);
        it.sidx  = 3'($urandom);
        it.value = {$urandom, $urandom};
        it.dbyte = 8'($urandom);
        return it;
    endfunction

    task automatic write_salt_enable(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        salt_on = v;
    endtask

    // sender holds off until every digest word is out, then lets the back end drain
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_traffic(input int n_items);
        int    sent;
        int    len;
        stim_t it;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = 47;
                2:       len = 48;
                3:       len = 63;
                4:       len = 64;
                5:       len = ($urandom_range(0, 1)) ? 65 : 112;
                default: len = $urandom_range(1, 12);
            endcase
            if (len > 20 && $urandom_range(0, 2) != 0)
                len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                // occasional store writes in the middle of a message
                if ($urandom_range(0, 19) == 0)
                begin
                    it = rand_item($urandom_range(0, 1) ? KIND_MATRIX : KIND_SALT);
                    send_item(it);
                    sent++;
                end
                send_item(rand_item(KIND_BYTE));
                sent++;
            end
            // some messages are left open and run into the next one
            if ($urandom_range(0, 7) != 0)
                send_item(rand_item(KIND_FINISH));
            sent++;
        end
    endtask

    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);

    // handshakes are looked at mid-cycle, where inputs and outputs are settled
    always @(negedge clk)
    begin
        digest_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                    report_mismatch("digest word with nothing expected");
                else
                begin
                    e = digest_q.pop_front();
                    if (m_tdata[63:0] !== e.word)
                        report_mismatch($sformatf("digest_word %h, expected %h",
                                                  m_tdata[63:0], e.word));
                    if (m_tdata[66:64] !== e.idx)
                        report_mismatch($sformatf("word_index %0d, expected %0d",
                                                  m_tdata[66:64], e.idx));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("last_word %b, expected %b",
                                                  m_tlast, e.last));
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    stim_t dir_tab [12] = '{
        '{KIND_MATRIX, 3'd0, 10'd0,    3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
        '{KIND_MATRIX, 3'd7, 10'd1023, 3'd7, 64'h0,                   8'hFF},
        '{KIND_MATRIX, 3'd7, 10'd1023, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
        '{KIND_SALT,   3'd0, 10'd0,    3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
        '{KIND_SALT,   3'd7, 10'd1023, 3'd7, 64'h0,                   8'hFF},
        '{KIND_FINISH, 3'd0, 10'd0,    3'd0, 64'h0,                   8'h00},
        '{KIND_BYTE,   3'd7, 10'd1023, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
        '{KIND_BYTE,   3'd0, 10'd0,    3'd0, 64'h0,                   8'hFF},
        '{KIND_BYTE,   3'd0, 10'd0,    3'd0, 64'h0,                   8'h80},
        '{KIND_FINISH, 3'd7, 10'd1023, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF},
        '{KIND_BYTE,   3'd2, 10'd512,  3'd4, 64'h8000_0000_0000_0001, 8'h5A},
        '{KIND_FINISH, 3'd5, 10'd341,  3'd2, 64'h5555_AAAA_5555_AAAA, 8'hA5}
    };

    initial
    begin
        stim_t it;
        chain   = '{default: '0};
        bit_cnt = '0;
        fill    = 0;
        started = 1'b0;
        salt_on = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_salt_enable(1'b0);

        // every matrix and salt word is loaded before any compression reads it
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 1024; c++)
            begin
                it = rand_item(KIND_MATRIX);
                it.row = 3'(r);
                it.col = 10'(c);
                send_item(it);
            end
        for (int i = 0; i < 8; i++)
        begin
            it = rand_item(KIND_SALT);
            it.sidx = 3'(i);
            send_item(it);
        end

        foreach (dir_tab[k])
            send_item(dir_tab[k]);

        wait_drained();
        write_salt_enable(1'b1);
        // empty message with salting on
        send_item(rand_item(KIND_FINISH));
        random_traffic(50);
        // leave a message open across the salt switch
        for (int i = 0; i < 5; i++)
            send_item(rand_item(KIND_BYTE));

        wait_drained();
        write_salt_enable(1'b0);
        calm = 1'b1;
        random_traffic(25);
        calm = 1'b0;
        random_traffic(30);
        send_item(rand_item(KIND_FINISH));

        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/sshash_pkg.sv
hdl/sshash_front.sv
hdl/sshash_core.sv
hdl/subset_sum_hash_512.sv
verif/tb_subset_sum_hash_512.sv
